>>> rtl/mse_pkg.sv
package mse_pkg;

    localparam int MAX_VALUES = 64;
    localparam int MAX_ITEMS  = 8;
    localparam int VALUE_BITS = 16;

    localparam int ADDR_W  = $clog2(MAX_VALUES);
    localparam int VCNT_W  = 7;
    localparam int CNT_W   = 4;
    localparam int TGT_W   = 19;
    localparam int SUM_W   = 20;
    localparam int POS_W   = 3;
    localparam int SLOT_W  = $clog2(MAX_ITEMS);
    localparam int DEPTH_W = $clog2(MAX_ITEMS + 1);
    localparam int REG_W   = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    localparam logic [REG_W-1:0] REG_TARGET_SUM  = 2'd0;
    localparam logic [REG_W-1:0] REG_MIN_COUNT   = 2'd1;
    localparam logic [REG_W-1:0] REG_MAX_COUNT   = 2'd2;
    localparam logic [REG_W-1:0] REG_VALUE_COUNT = 2'd3;

    typedef struct packed {
        logic [TGT_W-1:0]  target_sum;
        logic [CNT_W-1:0]  min_count;
        logic [CNT_W-1:0]  max_count;
        logic [VCNT_W-1:0] value_count;
    } t_cfg;

    typedef struct packed {
        logic                  cmd;
        logic [ADDR_W-1:0]     entry_index;
        logic [VALUE_BITS-1:0] value_word;
    } t_cmd;

    typedef struct packed {
        logic [VALUE_BITS-1:0] element_value;
        logic [POS_W-1:0]      position;
        logic                  is_last;
        logic                  exhausted;
    } t_res;

endpackage

>>> rtl/mse_engine.sv
module mse_engine import mse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    output logic o_cmd_ready,
    input  t_cmd i_cmd,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN      = 3'd1;
    localparam logic [2:0] S_LOOP      = 3'd2;
    localparam logic [2:0] S_ADV       = 3'd3;
    localparam logic [2:0] S_EMIT_RD   = 3'd4;
    localparam logic [2:0] S_EMIT_WAIT = 3'd5;
    localparam logic [2:0] S_EXH       = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [DEPTH_W-1:0]    r_d, n_d;
    logic [CNT_W-1:0]      r_k, n_k;
    logic                  r_started, n_started;
    logic                  r_done, n_done;
    logic                  r_desc, n_desc;
    logic [VCNT_W-1:0]     r_scan_i, n_scan_i;
    logic                  r_scan_vld, n_scan_vld;
    logic [VALUE_BITS-1:0] r_vmax, n_vmax;
    logic [CNT_W-1:0]      r_j, n_j;

    logic [ADDR_W-1:0]     r_stack  [MAX_ITEMS];
    logic [SUM_W-1:0]      r_prefix [MAX_ITEMS+1];
    logic [VALUE_BITS-1:0] r_mem    [MAX_VALUES];
    logic [VALUE_BITS-1:0] r_rdata;

    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_ra;
    logic                  stk_we;
    logic [SLOT_W-1:0]     stk_wa, stk_ra, dm1;
    logic [ADDR_W-1:0]     stk_wd, stk_rd, st;
    logic                  pf_we;
    logic [DEPTH_W-1:0]    pf_wa;
    logic [SUM_W-1:0]      pf_wd, pf_rd, adv_sum, tgt;
    logic [VCNT_W-1:0]     n_lim, nx;
    logic [CNT_W-1:0]      kmax, restart_k, kd;
    logic [CNT_W+VALUE_BITS-1:0] prod;
    logic [SUM_W:0]        bound;
    logic                  stop, prune, last_elem;

    assign n_lim = (i_cfg.value_count > VCNT_W'(MAX_VALUES)) ? VCNT_W'(MAX_VALUES)
                                                              : i_cfg.value_count;
    assign kmax  = (i_cfg.max_count > CNT_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS)
                                                          : i_cfg.max_count;
    assign restart_k = (i_cfg.min_count == '0) ? CNT_W'(1) : i_cfg.min_count;
    assign tgt = SUM_W'(i_cfg.target_sum);

    assign dm1    = (r_d == '0) ? '0 : SLOT_W'(r_d - 1'b1);
    assign stk_ra = (r_state == S_EMIT_RD) ? r_j[SLOT_W-1:0] : dm1;
    assign stk_rd = r_stack[stk_ra];
    assign pf_rd  = r_prefix[r_d];

    assign st   = (r_d == '0) ? '0 : stk_rd;
    assign nx   = {1'b0, stk_rd} + 1'b1;
    assign kd   = r_k - CNT_W'(r_d);
    // remaining slots filled with the largest value still fall short
    assign prod  = {{VALUE_BITS{1'b0}}, kd} * {{CNT_W{1'b0}}, r_vmax};
    assign bound = {1'b0, pf_rd} + (SUM_W+1)'(prod);
    assign prune = bound < {1'b0, tgt};
    assign stop  = (r_k > kmax) || (CNT_W'(r_d) > r_k) || (r_d > DEPTH_W'(MAX_ITEMS));

    assign adv_sum   = pf_rd + SUM_W'(r_rdata);
    assign last_elem = (r_j + 1'b1) == r_k;

    assign o_cmd_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_d        = r_d;
        n_k        = r_k;
        n_started  = r_started;
        n_done     = r_done;
        n_desc     = r_desc;
        n_scan_i   = r_scan_i;
        n_scan_vld = 1'b0;
        n_vmax     = r_vmax;
        n_j        = r_j;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_ra     = '0;
        stk_we     = 1'b0;
        stk_wa     = dm1;
        stk_wd     = st;
        pf_we      = 1'b0;
        pf_wa      = '0;
        pf_wd      = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.cmd == CMD_LOAD) begin
                        mem_we    = 1'b1;
                        n_started = 1'b0;
                        n_done    = 1'b0;
                        n_d       = '0;
                        n_k       = restart_k;
                    end else if (r_done) begin
                        n_state = S_EXH;
                    end else begin
                        n_state  = S_SCAN;
                        n_scan_i = '0;
                        n_vmax   = '0;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan_vld && (r_rdata > r_vmax)) begin
                    n_vmax = r_rdata;
                end
                if (r_scan_i < n_lim) begin
                    mem_re     = 1'b1;
                    mem_ra     = r_scan_i[ADDR_W-1:0];
                    n_scan_i   = r_scan_i + 1'b1;
                    n_scan_vld = 1'b1;
                end else if (!r_scan_vld) begin
                    n_state = S_LOOP;
                    if (!r_started) begin
                        n_started = 1'b1;
                        n_d       = '0;
                        pf_we     = 1'b1;
                        n_desc    = 1'b1;
                    end else begin
                        n_desc = 1'b0;
                    end
                end
            end
            S_LOOP: begin
                if (stop) begin
                    n_done  = 1'b1;
                    n_state = S_EXH;
                end else if (r_desc) begin
                    if (CNT_W'(r_d) == r_k) begin
                        if (pf_rd == tgt) begin
                            n_state = S_EMIT_RD;
                            n_j     = '0;
                        end else begin
                            n_desc = 1'b0;
                        end
                    end else if (prune) begin
                        n_desc = 1'b0;
                    end else if ({1'b0, st} >= n_lim) begin
                        n_desc = 1'b0;
                    end else begin
                        stk_we  = 1'b1;
                        stk_wa  = r_d[SLOT_W-1:0];
                        stk_wd  = st;
                        mem_re  = 1'b1;
                        mem_ra  = st;
                        n_state = S_ADV;
                    end
                end else begin
                    if (r_d == '0) begin
                        n_k    = r_k + 1'b1;
                        pf_we  = 1'b1;
                        n_desc = 1'b1;
                    end else begin
                        n_d = r_d - 1'b1;
                        if (nx < n_lim) begin
                            stk_we  = 1'b1;
                            stk_wa  = dm1;
                            stk_wd  = nx[ADDR_W-1:0];
                            mem_re  = 1'b1;
                            mem_ra  = nx[ADDR_W-1:0];
                            n_state = S_ADV;
                        end
                    end
                end
            end
            S_ADV: begin
                pf_we   = 1'b1;
                pf_wa   = r_d + 1'b1;
                pf_wd   = adv_sum;
                n_d     = r_d + 1'b1;
                n_desc  = adv_sum <= tgt;
                n_state = S_LOOP;
            end
            S_EMIT_RD: begin
                mem_re  = 1'b1;
                mem_ra  = stk_rd;
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                o_res_valid         = 1'b1;
                o_res.element_value = r_rdata;
                o_res.position      = r_j[POS_W-1:0];
                o_res.is_last       = last_elem;
                o_res.exhausted     = 1'b0;
                if (i_res_ready) begin
                    n_j     = r_j + 1'b1;
                    n_state = last_elem ? S_IDLE : S_EMIT_RD;
                end
            end
            S_EXH: begin
                o_res_valid     = 1'b1;
                o_res.is_last   = 1'b1;
                o_res.exhausted = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_d        <= '0;
            r_k        <= CNT_W'(1);
            r_started  <= 1'b0;
            r_done     <= 1'b0;
            r_desc     <= 1'b0;
            r_scan_i   <= '0;
            r_scan_vld <= 1'b0;
            r_j        <= '0;
        end else begin
            r_state    <= n_state;
            r_d        <= n_d;
            r_k        <= n_k;
            r_started  <= n_started;
            r_done     <= n_done;
            r_desc     <= n_desc;
            r_scan_i   <= n_scan_i;
            r_scan_vld <= n_scan_vld;
            r_j        <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vmax <= n_vmax;
        if (stk_we) begin
            r_stack[stk_wa] <= stk_wd;
        end
        if (pf_we) begin
            r_prefix[pf_wa] <= pf_wd;
        end
    end

    // value table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.entry_index] <= i_cmd.value_word;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    ap_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d <= DEPTH_W'(MAX_ITEMS))
        else $error("search depth beyond stack");

    ap_emit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.exhausted |-> CNT_W'(r_d) == r_k)
        else $error("set emitted from partial stack");

    ap_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && o_cmd_ready && (i_cmd.cmd == CMD_LOAD)
        |=> !r_started && !r_done && (r_d == '0))
        else $error("load did not restart search");

    ap_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> !r_scan_vld && !o_res_valid)
        else $error("idle with work pending");

    ap_loop_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> !r_done)
        else $error("search running after exhaustion");

endmodule

>>> rtl/multiset_sum_enumerator_unit.sv
// Enumerates multisets of the loaded table values that sum to target_sum, with
// sizes from min_count to max_count, sizes in ascending order and a depth-first
// walk over non-decreasing table indices within each size. A load word (tuser 0)
// writes one table entry and restarts the walk. A next word
// (tuser 1) first scans the table entries in use (value_count, capped at 64) for
// the largest value, then runs the search, whose length depends on the data; each
// table fetch adds an advance step after the search step. A found set leaves as
// one word per element, each read through the single table read port, tlast on
// the final element; with no set left a single exhausted word follows.
// Input is accepted only while the search sequencer is idle; the output register
// lets the next word be taken while a result still waits.
module multiset_sum_enumerator_unit import mse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [REG_W-1:0]  i_cfg_idx,
    input  logic [TGT_W-1:0]  i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // entry_index, value_word
    input  logic [0:0]        s_axis_tuser,   // cmd
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // element_value, position
    output logic              m_axis_tlast,
    output logic [0:0]        m_axis_tuser    // exhausted
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_res res, r_out;
    logic res_valid, res_ready, r_out_vld;

    assign cmd.cmd         = s_axis_tuser[0];
    assign cmd.entry_index = s_axis_tdata[ADDR_W-1:0];
    assign cmd.value_word  = s_axis_tdata[ADDR_W+VALUE_BITS-1:ADDR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_sum  <= TGT_W'(1);
            r_cfg.min_count   <= CNT_W'(1);
            r_cfg.max_count   <= CNT_W'(8);
            r_cfg.value_count <= VCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET_SUM:  r_cfg.target_sum  <= i_cfg_data;
                REG_MIN_COUNT:   r_cfg.min_count   <= i_cfg_data[CNT_W-1:0];
                REG_MAX_COUNT:   r_cfg.max_count   <= i_cfg_data[CNT_W-1:0];
                REG_VALUE_COUNT: r_cfg.value_count <= i_cfg_data[VCNT_W-1:0];
                default: ;
            endcase
        end
    end

    mse_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (s_axis_tvalid),
        .o_cmd_ready (s_axis_tready),
        .i_cmd       (cmd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = {5'b0, r_out.position, r_out.element_value};
    assign m_axis_tlast    = r_out.is_last;
    assign m_axis_tuser[0] = r_out.exhausted;

endmodule

>>> bench/multiset_sum_enumerator_unit_test.sv
`timescale 1ns / 1ps

module multiset_sum_enumerator_unit_test import mse_pkg::*; ;

    localparam int unsigned WATCHDOG_LIMIT = 50000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned END_WAIT       = 100;
    localparam int unsigned RANDOM_ITEMS   = 30;
    localparam int unsigned SQUEEZE_HOLD   = 400;

    class multiset_board;
        logic [VALUE_BITS-1:0] table_mem [MAX_VALUES];
        int unsigned           slot_idx [MAX_ITEMS];
        longint unsigned       run_sum [MAX_ITEMS+1];
        int unsigned           depth_now;
        int unsigned           size_now;
        bit                    walk_started;
        bit                    walk_done;
        longint unsigned       target_reg, min_reg, max_reg, count_reg;
        t_res                  expected_q [$];
        int unsigned           errors;

        function new();
            target_reg = 1;
            min_reg    = 1;
            max_reg    = 8;
            count_reg  = 1;
            errors     = 0;
            foreach (table_mem[i]) table_mem[i] = '0;
            restart_walk();
            size_now = 1;
        endfunction

        function void restart_walk();
            foreach (slot_idx[i]) slot_idx[i] = 0;
            foreach (run_sum[i]) run_sum[i] = 0;
            depth_now    = 0;
            size_now     = (min_reg == 0) ? 1 : int'(min_reg);
            walk_started = 0;
            walk_done    = 0;
        endfunction

        function void write_reg(logic [REG_W-1:0] idx, logic [TGT_W-1:0] data);
            case (idx)
                REG_TARGET_SUM:  target_reg = data;
                REG_MIN_COUNT:   min_reg    = data[CNT_W-1:0];
                REG_MAX_COUNT:   max_reg    = data[CNT_W-1:0];
                REG_VALUE_COUNT: count_reg  = data[VCNT_W-1:0];
                default: ;
            endcase
        endfunction

        // depth-first walk to the next multiset hitting the target
        function bit find_next_set();
            longint unsigned n, kmax, vmax, s, st, nx;
            int unsigned     k, d, i;
            bit              down;
            n    = (count_reg > MAX_VALUES) ? MAX_VALUES : count_reg;
            kmax = (max_reg > MAX_ITEMS) ? MAX_ITEMS : max_reg;
            vmax = 0;
            for (i = 0; i < n; i++)
                if (table_mem[i] > vmax) vmax = table_mem[i];
            if (!walk_started) begin
                walk_started = 1;
                depth_now    = 0;
                run_sum[0]   = 0;
                down         = 1;
            end else begin
                down = 0;
            end
            while (1) begin
                k = size_now;
                d = depth_now;
                if (k > kmax || d > k || d > MAX_ITEMS) begin
                    walk_done = 1;
                    return 0;
                end
                if (down) begin
                    s = run_sum[d];
                    if (d == k) begin
                        if (s == target_reg) return 1;
                        down = 0;
                    end else if (s + longint'(k - d) * vmax < target_reg) begin
                        down = 0;
                    end else begin
                        st = (d != 0) ? slot_idx[d-1] : 0;
                        if (st >= n) begin
                            down = 0;
                        end else begin
                            slot_idx[d]  = int'(st);
                            run_sum[d+1] = s + table_mem[st];
                            depth_now    = d + 1;
                            if (run_sum[d+1] > target_reg) down = 0;
                        end
                    end
                end else begin
                    if (d == 0) begin
                        size_now   = k + 1;
                        run_sum[0] = 0;
                        down       = 1;
                    end else begin
                        d--;
                        depth_now = d;
                        nx = slot_idx[d] + 1;
                        if (nx < n) begin
                            slot_idx[d]  = int'(nx);
                            run_sum[d+1] = run_sum[d] + table_mem[nx];
                            depth_now    = d + 1;
                            if (run_sum[d+1] <= target_reg) down = 1;
                        end
                    end
                end
            end
            return 0;
        endfunction

        function void note_word(t_cmd w);
            t_res        r;
            int unsigned j;
            if (w.cmd == CMD_LOAD) begin
                table_mem[w.entry_index] = w.value_word;
                restart_walk();
                return;
            end
            if (walk_done || !find_next_set()) begin
                walk_done   = 1;
                r           = '0;
                r.is_last   = 1'b1;
                r.exhausted = 1'b1;
                expected_q.push_back(r);
                return;
            end
            for (j = 0; j < size_now && j < MAX_ITEMS; j++) begin
                r.element_value = table_mem[slot_idx[j]];
                r.position      = POS_W'(j);
                r.is_last       = (j + 1 == size_now);
                r.exhausted     = 1'b0;
                expected_q.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_word(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual value %0h pos %0d last %0b exh %0b",
                         $time, got.element_value, got.position, got.is_last, got.exhausted);
                return;
            end
            want = expected_q.pop_front();
            compare_field("element_value", 32'(want.element_value), 32'(got.element_value));
            compare_field("position", 32'(want.position), 32'(got.position));
            compare_field("is_last", 32'(want.is_last), 32'(got.is_last));
            compare_field("exhausted", 32'(want.exhausted), 32'(got.exhausted));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [REG_W-1:0]  i_cfg_idx     = '0;
    logic [TGT_W-1:0]  i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata  = '0;   // entry_index, value_word
    logic [0:0]        s_axis_tuser  = '0;   // cmd
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;         // element_value, position
    logic              m_axis_tlast;
    logic [0:0]        m_axis_tuser;         // exhausted

    multiset_board board;
    t_cmd          seen_cmd;
    t_res          seen_res;
    int unsigned   quiet_cycles  = 0;
    int unsigned   words_sent    = 0;
    int unsigned   sink_hold_req = 0;
    bit            src_steady    = 0;
    bit            sink_steady   = 0;

    multiset_sum_enumerator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
    endfunction

    task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] idx,
                             input logic [VALUE_BITS-1:0] val);
        bit          taken;
        int unsigned pause;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, val, idx};
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end
        words_sent++;
        if (!src_steady) begin
            pause = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            if (pause != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
        end
    endtask

    task automatic request_sets(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
            send_word(CMD_NEXT, ADDR_W'($urandom()), VALUE_BITS'($urandom()));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [REG_W-1:0] idx, input logic [TGT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        board.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // junk in the unused upper bits of the narrow registers
    task automatic program_regs(input int unsigned tgt, input int unsigned mn,
                                input int unsigned mx, input int unsigned vc);
        cfg_write(REG_TARGET_SUM, TGT_W'(tgt));
        cfg_write(REG_MIN_COUNT, TGT_W'(($urandom() << CNT_W) | mn));
        cfg_write(REG_MAX_COUNT, TGT_W'(($urandom() << CNT_W) | mx));
        cfg_write(REG_VALUE_COUNT, TGT_W'(($urandom() << VCNT_W) | vc));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_episode(input bit squeeze);
        logic [VALUE_BITS-1:0] vals [MAX_VALUES];
        int unsigned           n, mn, mx, tgt, k, i, asks;
        bit                    tiny;
        wait_drained();
        src_steady  = squeeze || ($urandom_range(0, 4) == 0);
        sink_steady = !squeeze && ($urandom_range(0, 4) == 0);
        if (squeeze) begin
            n  = 4;
            mx = 4;
        end else if ($urandom_range(0, 4) != 0) begin
            n  = $urandom_range(1, 6);
            mx = $urandom_range(1, 5);
        end else begin
            n  = $urandom_range(7, 12);
            mx = $urandom_range(1, 3);
        end
        if (squeeze) begin
            mn = 1;
        end else begin
            case ($urandom_range(0, 9))
                0: mn = 0;
                1: mn = mx + 1;
                default: mn = $urandom_range(1, mx);
            endcase
        end
        tiny = squeeze || ($urandom_range(0, 2) != 0);
        for (i = 0; i < n; i++)
            vals[i] = VALUE_BITS'(tiny ? $urandom_range(0, 7) : $urandom_range(0, 65535));
        if (mn > mx) k = mx;
        else if (mn == 0) k = $urandom_range(1, mx);
        else k = $urandom_range(mn, mx);
        tgt = 0;
        for (i = 0; i < k; i++) tgt += vals[$urandom_range(0, n - 1)];
        program_regs(tgt, mn, mx, n);
        for (i = 0; i < n; i++) send_word(CMD_LOAD, ADDR_W'(i), vals[i]);
        asks = squeeze ? 10 : $urandom_range(2, 14);
        if (squeeze) sink_hold_req = SQUEEZE_HOLD;
        for (i = 0; i < asks; i++) begin
            if (!squeeze && $urandom_range(0, 11) == 0)
                send_word(CMD_LOAD, ADDR_W'($urandom_range(0, 63)), VALUE_BITS'($urandom()));
            else
                request_sets(1);
        end
    endtask

    // sink: random backpressure plus on-demand long hold
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0) begin
                if (sink_hold_req != 0) begin
                    hold_left     = sink_hold_req;
                    sink_hold_req = 0;
                end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
                    hold_left = gap_len();
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen_cmd.cmd         = s_axis_tuser[0];
                seen_cmd.entry_index = s_axis_tdata[ADDR_W-1:0];
                seen_cmd.value_word  = s_axis_tdata[ADDR_W +: VALUE_BITS];
                board.note_word(seen_cmd);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen_res.element_value = m_axis_tdata[VALUE_BITS-1:0];
                seen_res.position      = m_axis_tdata[VALUE_BITS +: POS_W];
                seen_res.is_last       = m_axis_tlast;
                seen_res.exhausted     = m_axis_tuser[0];
                board.check_word(seen_res);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("** multiset_sum_enumerator_unit: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [VALUE_BITS-1:0] fill_vals [MAX_VALUES];
        int unsigned           i, base, ep, tgt;
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one-value table, single hit then exhausted twice
        send_word(CMD_LOAD, ADDR_W'(0), VALUE_BITS'(1));
        request_sets(3);

        // largest target, largest set
        wait_drained();
        program_regs(524280, 8, 8, 2);
        send_word(CMD_LOAD, ADDR_W'(0), VALUE_BITS'(16'hFFFF));
        send_word(CMD_LOAD, ADDR_W'(1), VALUE_BITS'(0));
        request_sets(2);

        // zero target, zero start size, size bound past the eight-item set limit
        wait_drained();
        program_regs(0, 0, 15, 2);
        send_word(CMD_LOAD, ADDR_W'(1), VALUE_BITS'(0));
        request_sets(3);

        // empty table in use
        wait_drained();
        program_regs(5, 1, 3, 0);
        send_word(CMD_LOAD, ADDR_W'(63), VALUE_BITS'($urandom()));
        request_sets(1);

        // min above max
        wait_drained();
        program_regs(3, 5, 2, 2);
        send_word(CMD_LOAD, ADDR_W'(0), VALUE_BITS'(1));
        request_sets(1);

        // max of zero
        wait_drained();
        program_regs(1, 1, 0, 2);
        send_word(CMD_LOAD, ADDR_W'(0), VALUE_BITS'(1));
        request_sets(1);

        // target changed between words of one walk
        wait_drained();
        program_regs(4, 1, 4, 2);
        send_word(CMD_LOAD, ADDR_W'(1), VALUE_BITS'(2));
        request_sets(2);
        wait_drained();
        cfg_write(REG_TARGET_SUM, TGT_W'(6));
        i_cfg_we <= 1'b0;
        request_sets(2);

        // whole table, count above table size, then exactly full
        wait_drained();
        src_steady = 1;
        for (i = 0; i < MAX_VALUES; i++) begin
            fill_vals[i] = VALUE_BITS'($urandom());
            send_word(CMD_LOAD, ADDR_W'(i), fill_vals[i]);
        end
        wait_drained();
        src_steady = 0;
        tgt = fill_vals[$urandom_range(0, 63)] + fill_vals[$urandom_range(0, 63)];
        program_regs(tgt, 1, 2, 127);
        request_sets(4);
        wait_drained();
        tgt = fill_vals[$urandom_range(0, 63)];
        program_regs(tgt, 1, 2, 64);
        request_sets(1);
        send_word(CMD_LOAD, ADDR_W'(63), fill_vals[63]);
        request_sets(3);

        base = words_sent;
        ep = 0;
        while (words_sent - base < RANDOM_ITEMS) begin
            run_episode(ep == 0);
            ep++;
        end

        wait_drained();
        repeat (END_WAIT) @(posedge i_clk);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("** multiset_sum_enumerator_unit: PASSED **");
        end else begin
            $display("** multiset_sum_enumerator_unit: FAILED **");
        end
        $finish;
    end

endmodule
